// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define CMBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Antecedent this cycle, consequent next cycle.
`define CMBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cmbs_pkg.sv =====
// ---------------------------------------------------------------------------
// cmbs_pkg
// Types and constants of the running-mean background subtraction core.
// ---------------------------------------------------------------------------
package cmbs_pkg;

    localparam int MAX_PIXELS_DEF     = 524288;
    localparam int COUNT_BITS_DEF     = 16;
    localparam int MEAN_FRAC_BITS_DEF = 8;

    localparam int PIX_W      = 8;   // one color channel
    localparam int IDX_IN_W   = 19;  // pixel_index port width
    localparam int DIV_STEPS  = 2;   // quotient bits per divider stage

    localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd20;
    localparam logic [PIX_W-1:0] PIX_FULL      = 8'd255;

    typedef enum logic
    {
        CFG_THRESHOLD  = 1'b0,
        CFG_TRAIL_MODE = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] r;
    } rgb_t;

    typedef struct packed
    {
        logic opaque;
        rgb_t color;
    } mv_t;

    localparam int MV_W = $bits(mv_t);

endpackage

// ===== rtl/core/cmbs_mem.sv =====
// ---------------------------------------------------------------------------
// cmbs_mem
// Single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cmbs_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/cmbs_div.sv =====
// ---------------------------------------------------------------------------
// cmbs_div
// Pipelined restoring divider; quotient known to fit in MW bits.
// ---------------------------------------------------------------------------
module cmbs_div #(
    parameter int MW    = 16,
    parameter int CW    = 16,
    parameter int STEPS = cmbs_pkg::DIV_STEPS,
    parameter int NW    = MW + CW + 1
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [CW:0]   den,
    output logic [MW-1:0] quo
);
    import cmbs_pkg::*;

    localparam int ND = (MW + STEPS - 1) / STEPS;

    logic [CW:0]   rem_reg [ND];
    logic [MW-1:0] lo_reg  [ND];
    logic [CW:0]   den_reg [ND];

    logic [CW:0]   rem_in  [ND];
    logic [MW-1:0] lo_in   [ND];
    logic [CW:0]   den_in  [ND];
    logic [CW:0]   rem_next[ND];
    logic [MW-1:0] lo_next [ND];

    // high dividend bits start as remainder (already below den)
    assign rem_in[0] = num[NW-1:MW];
    assign lo_in[0]  = num[MW-1:0];
    assign den_in[0] = den;

    genvar k;
    generate
        for (k = 1; k < ND; k++)
        begin : g_link
            assign rem_in[k] = rem_reg[k-1];
            assign lo_in[k]  = lo_reg[k-1];
            assign den_in[k] = den_reg[k-1];
        end

        for (k = 0; k < ND; k++)
        begin : g_stage
            always_comb
            begin
                logic [CW:0]   r;
                logic [MW-1:0] l;
                logic [CW+1:0] t;
                r = rem_in[k];
                l = lo_in[k];
                for (int s = 0; s < STEPS; s++)
                begin
                    if (k * STEPS + s < MW)
                    begin
                        t = {r, l[MW-1]};
                        l = {l[MW-2:0], 1'b0};
                        if (t >= {1'b0, den_in[k]})
                        begin
                            r    = (CW+1)'(t - {1'b0, den_in[k]});
                            l[0] = 1'b1;
                        end
                        else
                        begin
                            r = t[CW:0];
                        end
                    end
                end
                rem_next[k] = r;
                lo_next[k]  = l;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next[k];
                    lo_reg[k]  <= lo_next[k];
                    den_reg[k] <= den_in[k];
                end
            end
        end
    endgenerate

    assign quo = lo_reg[ND-1];

endmodule

// ===== rtl/core/cumulative_mean_background_subtract_core.sv =====
// ---------------------------------------------------------------------------
// cumulative_mean_background_subtract_core
// Per-pixel cumulative RGB mean with movement detection and motion trail.
// ---------------------------------------------------------------------------
// Takes one pixel per clock while in_stall is low and returns one result per
// pixel, in order. The pipeline runs memory read, multiply, sum, a pipelined
// divider at two quotient bits per stage, then compare/write-back into the
// output register. Sustained rate is one pixel per clock while no stall holds
// the flow. The per-pixel state lives in one RAM with one read and one
// write port; a pixel whose index matches a pixel still in flight is held
// off (in_stall high) until that pixel has been written back, so repeated
// indices within the pipeline's depth stall the input. MAX_PIXELS is
// taken to be a power of two; pixel_index is reduced by dropping high bits.
// The RAM needs no clearing: in the first frame the word read for a pixel
// is ignored. Configuration writes are always ready and must only be issued
// while the core is idle.
`include "assert_macros.svh"

module cumulative_mean_background_subtract_core #(
    parameter int MAX_PIXELS     = cmbs_pkg::MAX_PIXELS_DEF,
    parameter int COUNT_BITS     = cmbs_pkg::COUNT_BITS_DEF,
    parameter int MEAN_FRAC_BITS = cmbs_pkg::MEAN_FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  cmbs_pkg::cfg_reg_t         cfg_index,
    input  logic [cmbs_pkg::PIX_W-1:0] cfg_data,
    // pixel input
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [cmbs_pkg::IDX_IN_W-1:0] pixel_index,
    input  logic [cmbs_pkg::PIX_W-1:0] red,
    input  logic [cmbs_pkg::PIX_W-1:0] green,
    input  logic [cmbs_pkg::PIX_W-1:0] blue,
    input  logic                       frame_end,
    // result output
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [cmbs_pkg::PIX_W-1:0] bg_red,
    output logic [cmbs_pkg::PIX_W-1:0] bg_green,
    output logic [cmbs_pkg::PIX_W-1:0] bg_blue,
    output logic [cmbs_pkg::PIX_W-1:0] mv_red,
    output logic [cmbs_pkg::PIX_W-1:0] mv_green,
    output logic [cmbs_pkg::PIX_W-1:0] mv_blue,
    output logic                       mv_opaque
);
    import cmbs_pkg::*;

    localparam int IDX_W = $clog2(MAX_PIXELS);
    localparam int CW    = COUNT_BITS;
    localparam int FB    = MEAN_FRAC_BITS;
    localparam int MW    = PIX_W + FB;          // 8.F mean
    localparam int NW    = MW + CW + 1;         // dividend
    localparam int ND    = (MW + DIV_STEPS - 1) / DIV_STEPS;
    localparam int NS    = ND + 3;              // read, mult, sum, divider
    localparam int L     = NS - 1;
    localparam int MEMW  = 3 * MW + CW + MV_W;

    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    // ---------------- configuration ----------------
    logic [PIX_W-1:0] threshold_reg;
    logic             trail_reg;
    logic             first_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            trail_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_THRESHOLD:  threshold_reg <= cfg_data;
                CFG_TRAIL_MODE: trail_reg     <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic             out_valid_reg;
    logic             adv;
    logic             hazard;
    logic             accept;
    logic [IDX_W-1:0] in_idx;

    // side-band per stage
    logic             sv_reg    [NS];
    logic [IDX_W-1:0] sidx_reg  [NS];
    rgb_t             sx_reg    [NS];
    logic             sfirst_reg[NS];
    logic [CW-1:0]    sn1_reg   [1:NS-1];
    mv_t              smv_reg   [1:NS-1];

    generate
        if (IDX_W <= IDX_IN_W)
        begin : g_idx_trunc
            assign in_idx = pixel_index[IDX_W-1:0];
        end
        else
        begin : g_idx_ext
            assign in_idx = IDX_W'(pixel_index);
        end
    endgenerate

    // whole pipeline moves when the output register can take a result
    assign adv = !out_valid_reg || !out_stall;

    // read-modify-write hazard against every pixel still in flight
    always_comb
    begin
        hazard = 1'b0;
        for (int i = 0; i < NS; i++)
        begin
            if (sv_reg[i] && sidx_reg[i] == in_idx)
            begin
                hazard = 1'b1;
            end
        end
    end

    assign in_stall = !adv || hazard;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
        end
        else if (accept && frame_end)
        begin
            first_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                sv_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            sv_reg[0] <= accept;
            for (int i = 1; i < NS; i++)
            begin
                sv_reg[i] <= sv_reg[i-1];
            end
        end
    end

    // ---------------- state memory ----------------
    logic [MEMW-1:0] mem_q;
    logic [MEMW-1:0] mem_wdata;
    logic            mem_we;

    cmbs_mem #(
        .DEPTH (MAX_PIXELS),
        .WIDTH (MEMW),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (in_idx),
        .rd_data (mem_q),
        .wr_en   (mem_we),
        .wr_addr (sidx_reg[L]),
        .wr_data (mem_wdata)
    );

    // ---------------- stage A: decode read word ----------------
    logic [MW-1:0] mean_q[3];
    logic [MW-1:0] mean_a[3];
    logic [CW-1:0] cnt_q;
    mv_t           mv_q;
    logic [CW-1:0] n_a;
    logic [CW-1:0] n1_a;

    assign mean_q[0] = mem_q[MW-1:0];
    assign mean_q[1] = mem_q[2*MW-1:MW];
    assign mean_q[2] = mem_q[3*MW-1:2*MW];
    assign cnt_q     = mem_q[3*MW+CW-1:3*MW];
    assign mv_q      = mem_q[MEMW-1:3*MW+CW];

    // first frame: the entry may be unwritten, so the old mean is dropped
    assign mean_a[0] = sfirst_reg[0] ? '0 : mean_q[0];
    assign mean_a[1] = sfirst_reg[0] ? '0 : mean_q[1];
    assign mean_a[2] = sfirst_reg[0] ? '0 : mean_q[2];

    // first frame: n = 0 makes the divider return the sample itself
    assign n_a  = sfirst_reg[0] ? '0 : cnt_q;
    assign n1_a = sfirst_reg[0] ? CNT_ONE :
                  (cnt_q == CNT_MAX) ? CNT_MAX : CW'(cnt_q + CNT_ONE);

    logic [MW+CW-1:0] prod_reg[3];
    logic [CW:0]      den_b_reg;
    logic [NW-1:0]    num_reg [3];
    logic [CW:0]      den_c_reg;
    logic [MW-1:0]    xs_b[3];

    assign xs_b[0] = MW'(sx_reg[1].r) << FB;
    assign xs_b[1] = MW'(sx_reg[1].g) << FB;
    assign xs_b[2] = MW'(sx_reg[1].b) << FB;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // side-band payload
            sidx_reg[0]   <= in_idx;
            sx_reg[0]     <= '{b: blue, g: green, r: red};
            sfirst_reg[0] <= first_reg;
            for (int i = 1; i < NS; i++)
            begin
                sidx_reg[i]   <= sidx_reg[i-1];
                sx_reg[i]     <= sx_reg[i-1];
                sfirst_reg[i] <= sfirst_reg[i-1];
            end
            sn1_reg[1] <= n1_a;
            smv_reg[1] <= mv_q;
            for (int i = 2; i < NS; i++)
            begin
                sn1_reg[i] <= sn1_reg[i-1];
                smv_reg[i] <= smv_reg[i-1];
            end
            // stage B: mean * n
            for (int c = 0; c < 3; c++)
            begin
                prod_reg[c] <= mean_a[c] * n_a;
            end
            den_b_reg <= (CW+1)'(n_a) + (CW+1)'(1);
            // stage C: numerator with round-half-up term
            for (int c = 0; c < 3; c++)
            begin
                num_reg[c] <= NW'(prod_reg[c]) + NW'(xs_b[c]) + NW'(den_b_reg >> 1);
            end
            den_c_reg <= den_b_reg;
        end
    end

    // ---------------- divider stages ----------------
    logic [MW-1:0] mean_new[3];

    genvar c;
    generate
        for (c = 0; c < 3; c++)
        begin : g_div
            cmbs_div #(
                .MW    (MW),
                .CW    (CW),
                .STEPS (DIV_STEPS),
                .NW    (NW)
            ) u_div (
                .clk (clk),
                .en  (adv),
                .num (num_reg[c]),
                .den (den_c_reg),
                .quo (mean_new[c])
            );
        end
    endgenerate

    // ---------------- final stage: movement and write-back ----------------
    logic [MW-1:0] xs_f[3];
    logic [MW:0]   ts_f;
    logic [2:0]    ch_moved;
    logic          moved;
    mv_t           mv_f;

    assign xs_f[0] = MW'(sx_reg[L].r) << FB;
    assign xs_f[1] = MW'(sx_reg[L].g) << FB;
    assign xs_f[2] = MW'(sx_reg[L].b) << FB;
    assign ts_f    = (MW+1)'(threshold_reg) << FB;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ch_moved[i] = ({1'b0, xs_f[i]} > {1'b0, mean_new[i]} + ts_f) ||
                          ({1'b0, xs_f[i]} + ts_f < {1'b0, mean_new[i]});
        end
    end

    assign moved = &ch_moved;

    always_comb
    begin
        if (!trail_reg || moved)
        begin
            mv_f = '{opaque: moved, color: sx_reg[L]};
        end
        else if (sfirst_reg[L])
        begin
            mv_f = '{opaque: 1'b1, color: '{b: PIX_FULL, g: PIX_FULL, r: PIX_FULL}};
        end
        else
        begin
            mv_f = smv_reg[L];
        end
    end

    assign mem_we    = adv && sv_reg[L];
    assign mem_wdata = {mv_f, sn1_reg[L], mean_new[2], mean_new[1], mean_new[0]};

    // ---------------- output register ----------------
    rgb_t bg_reg;
    mv_t  mv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= sv_reg[L];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bg_reg <= '{b: mean_new[2][MW-1:FB],
                        g: mean_new[1][MW-1:FB],
                        r: mean_new[0][MW-1:FB]};
            mv_reg <= mv_f;
        end
    end

    assign out_valid = out_valid_reg;
    assign bg_red    = bg_reg.r;
    assign bg_green  = bg_reg.g;
    assign bg_blue   = bg_reg.b;
    assign mv_red    = mv_reg.color.r;
    assign mv_green  = mv_reg.color.g;
    assign mv_blue   = mv_reg.color.b;
    assign mv_opaque = mv_reg.opaque;

    // ---------------- assertions ----------------
    `CMBS_ASSERT(a_no_raw_accept, (accept |-> !(sv_reg[0] && sidx_reg[0] == in_idx)), "pixel accepted over in-flight twin")
    `CMBS_ASSERT_NEXT(a_first_frame_ends, accept && frame_end, !first_reg, "first frame flag not cleared")
    `CMBS_ASSERT(a_out_from_pipe, ($rose(out_valid_reg) |-> $past(sv_reg[L])), "result without pipeline transaction")
    `CMBS_ASSERT_NEXT(a_freeze_on_stall, out_valid_reg && out_stall, sv_reg[L] == $past(sv_reg[L]), "pipeline moved while stalled")

endmodule
